@@ hdl/preemptive_priority_scheduler_defines.svh @@
// assertion helpers for the scheduler, sampled on clk and muted in reset
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/pps_pkg.sv @@
`default_nettype none

package pps_pkg;

	// table geometry
	localparam int MAX_JOBS = 16;
	localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);

	// input function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// one table entry
	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
		logic [7:0]  prio;
	} entry_t;

	// table write port
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_SHIFT,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

@@ hdl/pps_table.sv @@
`default_nettype none

module pps_table import pps_pkg::*; (
	input  wire logic             clk,
	input  wire tbl_wr_t          wr,
	input  wire logic [IDX_W-1:0] raddr,
	output entry_t                rdata
);

	entry_t mem [MAX_JOBS];

	// write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/pps_wait.sv @@
`default_nettype none

module pps_wait import pps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        add_en,
	input  wire logic [15:0] tick_time,
	input  wire logic [15:0] job_arrival,
	input  wire logic [15:0] job_burst,
	output logic [31:0]      wait_sum
);

	logic signed [17:0] diff;
	logic               diff_pos;
	logic [32:0]        sum_ext;
	logic [31:0]        sum_q;

	// wait of a finished job: completion minus arrival minus burst
	always_comb begin
		diff     = $signed({2'b00, tick_time}) + 18'sd1
			- $signed({2'b00, job_arrival}) - $signed({2'b00, job_burst});
		diff_pos = !diff[17] && (diff != 18'sd0);
		sum_ext  = {1'b0, sum_q} + {16'b0, diff[16:0]};
	end

	// saturating accumulator, negative waits add nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (add_en && diff_pos) begin
			sum_q <= sum_ext[32] ? '1 : sum_ext[31:0];
		end
	end

	assign wait_sum = sum_q;

endmodule

`default_nettype wire

@@ hdl/preemptive_priority_scheduler.sv @@
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// input    | in_valid/in_stall  | func, job_id, arrival_time, burst_time,
//          |                    | priority_req
// output   | out_valid/out_stall| cur_time, running_id, idle, switched, job_done,
//          |                    | total_wait, load_error
//
// a load goes from acceptance through the result state into the output register
// a tick scans N table entries one per cycle through the single read port,
// updates the chosen entry, then moves S later entries down one per cycle on completion
// arst_n clears the job count, clock, wait total and history; the table itself
// has no reset, only entries below the job count are ever used
// a waiting result sits in the output register and the next item is accepted
// meanwhile; the sequencer holds in its result state while out_stall is high and a result is still posted
`default_nettype none

module preemptive_priority_scheduler import pps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  job_id,
	input  wire logic [15:0] arrival_time,
	input  wire logic [15:0] burst_time,
	input  wire logic [7:0]  priority_req,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      cur_time,
	output logic [7:0]       running_id,
	output logic             idle,
	output logic             switched,
	output logic             job_done,
	output logic [31:0]      total_wait,
	output logic             load_error
);

	state_t           state_q, state_d;
	logic             in_acc;
	logic             out_free;
	logic             load_ok;

	logic [15:0]      t_q;
	logic [15:0]      time_now_q;
	logic [CNT_W-1:0] job_count_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic [IDX_W-1:0] sh_idx_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t           best_q;
	logic             found_q;
	logic             last_idle_q;
	logic [7:0]       last_running_q;

	logic [7:0]       res_run_q;
	logic             res_idle_q;
	logic             res_sw_q;
	logic             res_done_q;
	logic             res_lerr_q;

	logic             out_valid_q;
	logic [15:0]      cur_time_q;
	logic [7:0]       running_id_q;
	logic             idle_q;
	logic             switched_q;
	logic             job_done_q;
	logic [31:0]      total_wait_q;
	logic             load_error_q;

	tbl_wr_t          tbl_wr;
	logic [IDX_W-1:0] tbl_raddr;
	entry_t           tbl_rdata;
	logic             wait_en;
	logic [31:0]      wait_sum;

	logic             scan_hit;
	logic             scan_last;
	logic             sh_last;
	logic             best_done;
	logic             shift_need;
	logic             tick_sw;

	// handshake
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load_ok  = (burst_time != 16'd0) && (job_count_q < CNT_W'(MAX_JOBS));

	// scan compare: ready and strictly better than the best so far
	assign scan_hit = (tbl_rdata.arrival <= t_q) && (tbl_rdata.remaining != 16'd0)
		&& (!found_q || (tbl_rdata.prio < best_q.prio));
	assign scan_last  = (CNT_W'(scan_idx_q) + CNT_W'(1)) == job_count_q;
	assign sh_last    = (CNT_W'(sh_idx_q) + CNT_W'(1)) == job_count_q;
	assign best_done  = (best_q.remaining == 16'd1);
	assign shift_need = (CNT_W'(best_idx_q) + CNT_W'(1)) != job_count_q;
	assign tick_sw    = (found_q == last_idle_q)
		|| (found_q && (best_q.id != last_running_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (func == FUNC_LOAD) begin
						state_d = ST_RESULT;
					end else if (job_count_q == '0) begin
						state_d = ST_UPDATE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (found_q && best_done && shift_need) begin
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SHIFT: begin
				if (sh_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// table port and wait unit control
	always_comb begin
		tbl_wr.we   = 1'b0;
		tbl_wr.addr = job_count_q[IDX_W-1:0];
		tbl_wr.data = '{id: job_id, arrival: arrival_time, burst: burst_time,
			remaining: burst_time, prio: priority_req};
		tbl_raddr   = '0;
		wait_en     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				tbl_wr.we = in_acc && (func == FUNC_LOAD) && load_ok;
			end
			ST_SCAN: begin
				tbl_raddr = scan_idx_q + IDX_W'(1);
			end
			ST_UPDATE: begin
				tbl_wr.we             = found_q && !best_done;
				tbl_wr.addr           = best_idx_q;
				tbl_wr.data           = best_q;
				tbl_wr.data.remaining = best_q.remaining - 16'd1;
				tbl_raddr             = best_idx_q + IDX_W'(1);
				wait_en               = found_q && best_done;
			end
			ST_SHIFT: begin
				tbl_wr.we   = 1'b1;
				tbl_wr.addr = sh_idx_q - IDX_W'(1);
				tbl_wr.data = tbl_rdata;
				tbl_raddr   = sh_idx_q + IDX_W'(1);
			end
			default: begin
				tbl_wr.we = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_count_q    <= '0;
			time_now_q     <= '0;
			last_idle_q    <= 1'b1;
			last_running_q <= '0;
			found_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						found_q <= 1'b0;
						if ((func == FUNC_LOAD) && load_ok) begin
							job_count_q <= job_count_q + CNT_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						found_q <= 1'b1;
					end
				end
				ST_UPDATE: begin
					last_idle_q    <= !found_q;
					last_running_q <= found_q ? best_q.id : 8'd0;
					if (time_now_q != 16'hFFFF) begin
						time_now_q <= time_now_q + 16'd1;
					end
					if (found_q && best_done && !shift_need) begin
						job_count_q <= job_count_q - CNT_W'(1);
					end
				end
				ST_SHIFT: begin
					if (sh_last) begin
						job_count_q <= job_count_q - CNT_W'(1);
					end
				end
				default: begin
					found_q <= found_q;
				end
			endcase
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					t_q        <= time_now_q;
					scan_idx_q <= '0;
					res_run_q  <= '0;
					res_idle_q <= 1'b0;
					res_sw_q   <= 1'b0;
					res_done_q <= 1'b0;
					res_lerr_q <= (func == FUNC_LOAD) && (burst_time != 16'd0)
						&& !load_ok;
				end
			end
			ST_SCAN: begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (scan_hit) begin
					best_idx_q <= scan_idx_q;
					best_q     <= tbl_rdata;
				end
			end
			ST_UPDATE: begin
				res_run_q  <= found_q ? best_q.id : 8'd0;
				res_idle_q <= !found_q;
				res_sw_q   <= tick_sw;
				res_done_q <= found_q && best_done;
				sh_idx_q   <= best_idx_q + IDX_W'(1);
			end
			ST_SHIFT: begin
				sh_idx_q <= sh_idx_q + IDX_W'(1);
			end
			default: begin
				sh_idx_q <= sh_idx_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			cur_time_q   <= t_q;
			running_id_q <= res_run_q;
			idle_q       <= res_idle_q;
			switched_q   <= res_sw_q;
			job_done_q   <= res_done_q;
			total_wait_q <= wait_sum;
			load_error_q <= res_lerr_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign cur_time   = cur_time_q;
	assign running_id = running_id_q;
	assign idle       = idle_q;
	assign switched   = switched_q;
	assign job_done   = job_done_q;
	assign total_wait = total_wait_q;
	assign load_error = load_error_q;

	// job table
	pps_table u_table (
		.clk   (clk),
		.wr    (tbl_wr),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// waiting-time accumulator
	pps_wait u_wait (
		.clk         (clk),
		.arst_n      (arst_n),
		.add_en      (wait_en),
		.tick_time   (t_q),
		.job_arrival (best_q.arrival),
		.job_burst   (best_q.burst),
		.wait_sum    (wait_sum)
	);

	`include "preemptive_priority_scheduler_defines.svh"

	`PPS_ASSERT_NOW(a_count_bound, 1'b1, job_count_q <= CNT_W'(MAX_JOBS), "job count overflow")
	`PPS_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "item accepted but not busy")
	`PPS_ASSERT_NEXT(a_result_posted, (state_q == ST_RESULT) && out_free, out_valid, "result lost")
	`PPS_ASSERT_NOW(a_done_not_idle, out_valid, !(job_done && idle), "completion on idle tick")

endmodule

`default_nettype wire
